// ===== hw/rtl/ddo_pkg.sv =====
// ddo_pkg: shared types, codes and constant tables of the odometry core
// used by the channel interfaces, the controller, the datapath and the top level
package ddo_pkg;

    localparam int unsigned ATAN_LEN = 24;
    localparam int unsigned ITER_W   = 5;

    localparam logic [2:0] CFG_WHEEL_DIAMETER  = 3'd0;
    localparam logic [2:0] CFG_INV_WHEEL_SEP   = 3'd1;
    localparam logic [2:0] CFG_QUIESCENT_DRAIN = 3'd2;
    localparam logic [2:0] CFG_MOTION_DRAIN    = 3'd3;
    localparam logic [2:0] CFG_INITIAL_BATTERY = 3'd4;

    localparam logic [15:0] RST_WHEEL_DIAMETER  = 16'd12452;
    localparam logic [23:0] RST_INV_WHEEL_SEP   = 24'd187245;
    localparam logic [31:0] RST_QUIESCENT_DRAIN = 32'd2386093;
    localparam logic [31:0] RST_MOTION_DRAIN    = 32'd858993;
    localparam logic [23:0] RST_INITIAL_BATTERY = 24'd812646;

    // 1/K of the cordic in Q0.32, and 65536/(2*pi) in Q.8
    localparam logic [31:0] INV_GAIN_Q32   = 32'd2608131497;
    localparam logic [21:0] BAM_PER_RAD_Q8 = 22'd2670177;

    typedef struct packed {
        logic [23:0] step_time;
        logic [23:0] left_wheel_rate;
        logic [23:0] right_wheel_rate;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [31:0] linear_velocity;
        logic [31:0] angular_velocity;
        logic [23:0] battery_volts;
        logic        battery_empty;
    } t_out_item;

    typedef struct packed {
        logic        we;
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    // multiplier micro-operations, one per sequencer slot
    typedef enum logic [4:0] {
        MOP_NONE, MOP_PL, MOP_PR, MOP_LIN, MOP_ANGW, MOP_D1_LO, MOP_D1_HI, MOP_ANG,
        MOP_D2_LO, MOP_D2_HI, MOP_SQ1, MOP_DA_LO, MOP_DA_HI, MOP_X0, MOP_BAM_LO,
        MOP_BAM_HI, MOP_MT1_HI, MOP_MT1_LO, MOP_SQ2, MOP_QD, MOP_MT2_HI, MOP_MT2_LO
    } t_mop;

    typedef enum logic [4:0] {
        S_IDLE, S_PL, S_PR, S_LIN, S_ANGW, S_D1_LO, S_D1_HI, S_ANG, S_D2_LO, S_D2_HI,
        S_SQ1, S_DA_LO, S_DA_HI, S_X0, S_BAM_LO, S_BAM_HI, S_MT1_HI, S_MT1_LO, S_SQ2,
        S_QD, S_MT2_HI, S_MT2_LO, S_CINIT, S_CORDIC, S_COMMIT
    } t_state;

    typedef struct packed {
        logic              load_in;
        t_mop              mop;
        logic              cordic_init;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
        logic              commit;
    } t_cmd;

    // arctan(2^-i) with 2^32 units per circle
    function automatic logic [29:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ddo_in_if.sv =====
// ddo_in_if: input channel of the odometry core, valid/ready with one step item
// depends on ddo_pkg
interface ddo_in_if;
    logic              valid;
    logic              ready;
    ddo_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ddo_out_if.sv =====
// ddo_out_if: result channel of the odometry core, valid/ready with one pose item
// depends on ddo_pkg
interface ddo_out_if;
    logic               valid;
    logic               ready;
    ddo_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ddo_ctrl.sv =====
// ddo_ctrl: sequencer of the odometry core, issues multiplier slots and cordic steps
// depends on ddo_pkg
module ddo_ctrl #(
    parameter int unsigned N_ITER = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output ddo_pkg::t_cmd o_cmd
);
    import ddo_pkg::*;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(N_ITER - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    logic              commit_ok;

    assign commit_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_PL;
            S_PL:      n_state = S_PR;
            S_PR:      n_state = S_LIN;
            S_LIN:     n_state = S_ANGW;
            S_ANGW:    n_state = S_D1_LO;
            S_D1_LO:   n_state = S_D1_HI;
            S_D1_HI:   n_state = S_ANG;
            S_ANG:     n_state = S_D2_LO;
            S_D2_LO:   n_state = S_D2_HI;
            S_D2_HI:   n_state = S_SQ1;
            S_SQ1:     n_state = S_DA_LO;
            S_DA_LO:   n_state = S_DA_HI;
            S_DA_HI:   n_state = S_X0;
            S_X0:      n_state = S_BAM_LO;
            S_BAM_LO:  n_state = S_BAM_HI;
            S_BAM_HI:  n_state = S_MT1_HI;
            S_MT1_HI:  n_state = S_MT1_LO;
            S_MT1_LO:  n_state = S_SQ2;
            S_SQ2:     n_state = S_QD;
            S_QD:      n_state = S_MT2_HI;
            S_MT2_HI:  n_state = S_MT2_LO;
            S_MT2_LO:  n_state = S_CINIT;
            S_CINIT:   n_state = S_CORDIC;
            S_CORDIC:  if (r_iter == LAST_ITER) n_state = S_COMMIT;
            S_COMMIT:  if (commit_ok) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.mop   = MOP_NONE;
        o_cmd.iter  = r_iter;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_PL:      o_cmd.mop = MOP_PL;
            S_PR:      o_cmd.mop = MOP_PR;
            S_LIN:     o_cmd.mop = MOP_LIN;
            S_ANGW:    o_cmd.mop = MOP_ANGW;
            S_D1_LO:   o_cmd.mop = MOP_D1_LO;
            S_D1_HI:   o_cmd.mop = MOP_D1_HI;
            S_ANG:     o_cmd.mop = MOP_ANG;
            S_D2_LO:   o_cmd.mop = MOP_D2_LO;
            S_D2_HI:   o_cmd.mop = MOP_D2_HI;
            S_SQ1:     o_cmd.mop = MOP_SQ1;
            S_DA_LO:   o_cmd.mop = MOP_DA_LO;
            S_DA_HI:   o_cmd.mop = MOP_DA_HI;
            S_X0:      o_cmd.mop = MOP_X0;
            S_BAM_LO:  o_cmd.mop = MOP_BAM_LO;
            S_BAM_HI:  o_cmd.mop = MOP_BAM_HI;
            S_MT1_HI:  o_cmd.mop = MOP_MT1_HI;
            S_MT1_LO:  o_cmd.mop = MOP_MT1_LO;
            S_SQ2:     o_cmd.mop = MOP_SQ2;
            S_QD:      o_cmd.mop = MOP_QD;
            S_MT2_HI:  o_cmd.mop = MOP_MT2_HI;
            S_MT2_LO:  o_cmd.mop = MOP_MT2_LO;
            S_CINIT:   o_cmd.cordic_init = 1'b1;
            S_CORDIC:  o_cmd.cordic_step = 1'b1;
            S_COMMIT:  o_cmd.commit = commit_ok;
            default:   o_cmd.mop = MOP_NONE;
        endcase
    end

    always_comb begin
        n_iter = r_iter;
        if (r_state == S_CINIT) begin
            n_iter = '0;
        end else if (r_state == S_CORDIC) begin
            n_iter = r_iter + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/ddo_datapath.sv =====
// ddo_datapath: config registers, pose state, shared multiplier with accumulator,
// iterative cordic and result register of the odometry core; depends on ddo_pkg
module ddo_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddo_pkg::t_cfg_wr   i_cfg,
    input  ddo_pkg::t_cmd      i_cmd,
    input  ddo_pkg::t_in_item  i_in_data,
    output ddo_pkg::t_out_item o_out_data
);
    import ddo_pkg::*;

    // configuration
    logic [15:0] r_wd;
    logic [23:0] r_isep;
    logic [31:0] r_qd;
    logic [31:0] r_md;

    // pose state
    logic [31:0] r_pose_x;
    logic [31:0] r_pose_y;
    logic [15:0] r_heading;
    logic [23:0] r_battery;

    // item and intermediates
    logic [23:0] r_step, r_rl, r_rr;
    logic [39:0] r_pl, r_pr;
    logic [31:0] r_lin, r_ang;
    logic [25:0] r_angw;
    logic [38:0] r_d1, r_d2;
    logic [39:0] r_dat;
    logic [15:0] r_bam;
    logic [31:0] r_x0;
    logic [60:0] r_sq;
    logic [63:0] r_acc;
    logic [65:0] r_prod;
    t_mop        r_mop;
    logic signed [33:0] r_cx, r_cy, r_cz;
    t_out_item   r_out;

    // operand derivations
    logic [24:0] rsum, rdiff;
    logic [39:0] dsum, ddiff;
    logic [30:0] t1, t2, abs1, abs2;
    logic [32:0] mul_a, mul_b;

    assign rsum  = {r_rl[23], r_rl} + {r_rr[23], r_rr};
    assign rdiff = {r_rr[23], r_rr} - {r_rl[23], r_rl};
    assign dsum  = {r_d1[38], r_d1} + {r_d2[38], r_d2};
    assign ddiff = {r_d2[38], r_d2} - {r_d1[38], r_d1};
    assign t1    = r_d1[38:8];
    assign t2    = r_d2[38:8];
    assign abs1  = t1[30] ? (~t1 + 1'b1) : t1;
    assign abs2  = t2[30] ? (~t2 + 1'b1) : t2;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            MOP_PL: begin
                mul_a = {17'd0, r_wd};
                mul_b = {{9{r_rl[23]}}, r_rl};
            end
            MOP_PR: begin
                mul_a = {17'd0, r_wd};
                mul_b = {{9{r_rr[23]}}, r_rr};
            end
            MOP_LIN: begin
                mul_a = {17'd0, r_wd};
                mul_b = {{8{rsum[24]}}, rsum};
            end
            MOP_ANGW: begin
                mul_a = {17'd0, r_wd};
                mul_b = {{8{rdiff[24]}}, rdiff};
            end
            MOP_D1_LO: begin
                mul_a = {9'd0, r_step};
                mul_b = {1'b0, r_pl[31:0]};
            end
            MOP_D1_HI: begin
                mul_a = {9'd0, r_step};
                mul_b = {{25{r_pl[39]}}, r_pl[39:32]};
            end
            MOP_ANG: begin
                mul_a = {{7{r_angw[25]}}, r_angw};
                mul_b = {9'd0, r_isep};
            end
            MOP_D2_LO: begin
                mul_a = {9'd0, r_step};
                mul_b = {1'b0, r_pr[31:0]};
            end
            MOP_D2_HI: begin
                mul_a = {9'd0, r_step};
                mul_b = {{25{r_pr[39]}}, r_pr[39:32]};
            end
            MOP_SQ1: begin
                mul_a = {2'd0, abs1};
                mul_b = {2'd0, abs1};
            end
            MOP_DA_LO: begin
                mul_a = {1'b0, ddiff[31:0]};
                mul_b = {9'd0, r_isep};
            end
            MOP_DA_HI: begin
                mul_a = {{25{ddiff[39]}}, ddiff[39:32]};
                mul_b = {9'd0, r_isep};
            end
            MOP_X0: begin
                mul_a = {{2{dsum[39]}}, dsum[39:9]};
                mul_b = {1'b0, INV_GAIN_Q32};
            end
            MOP_BAM_LO: begin
                mul_a = {1'b0, r_dat[31:0]};
                mul_b = {11'd0, BAM_PER_RAD_Q8};
            end
            MOP_BAM_HI: begin
                mul_a = {{25{r_dat[39]}}, r_dat[39:32]};
                mul_b = {11'd0, BAM_PER_RAD_Q8};
            end
            MOP_MT1_HI, MOP_MT2_HI: begin
                mul_a = {4'd0, r_sq[60:32]};
                mul_b = {1'b0, r_md};
            end
            MOP_MT1_LO, MOP_MT2_LO: begin
                mul_a = {1'b0, r_sq[31:0]};
                mul_b = {1'b0, r_md};
            end
            MOP_SQ2: begin
                mul_a = {2'd0, abs2};
                mul_b = {2'd0, abs2};
            end
            MOP_QD: begin
                mul_a = {9'd0, r_step};
                mul_b = {1'b0, r_qd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // write-back of the product registered in the previous cycle
    logic [63:0] p_none, p_l32, p_r32, p_r8, p_sel, wb_val, bam_rnd;
    logic        acc_add, acc_wr;

    assign p_none = r_prod[63:0];
    assign p_l32  = {r_prod[31:0], 32'd0};
    assign p_r32  = {{30{r_prod[65]}}, r_prod[65:32]};
    assign p_r8   = {{6{r_prod[65]}}, r_prod[65:8]};

    always_comb begin
        p_sel   = p_none;
        acc_add = 1'b0;
        acc_wr  = 1'b0;
        case (r_mop)
            MOP_D1_LO, MOP_D2_LO, MOP_DA_LO, MOP_BAM_LO, MOP_MT1_HI: begin
                acc_wr = 1'b1;
            end
            MOP_D1_HI, MOP_D2_HI, MOP_DA_HI, MOP_BAM_HI: begin
                p_sel   = p_l32;
                acc_add = 1'b1;
                acc_wr  = 1'b1;
            end
            MOP_MT1_LO, MOP_MT2_LO: begin
                p_sel   = p_r32;
                acc_add = 1'b1;
                acc_wr  = 1'b1;
            end
            MOP_QD: begin
                p_sel   = p_r8;
                acc_add = 1'b1;
                acc_wr  = 1'b1;
            end
            MOP_MT2_HI: begin
                acc_add = 1'b1;
                acc_wr  = 1'b1;
            end
            default: begin
                p_sel = p_none;
            end
        endcase
        wb_val  = acc_add ? (r_acc + p_sel) : p_sel;
        bam_rnd = wb_val + 64'h0000_0000_8000_0000;
    end

    // cordic step and heading fold
    logic signed [33:0] xs, ys, atan_v, z_init, x_init;
    logic signed [16:0] h17, hf;
    logic               fold;

    assign xs     = r_cx >>> i_cmd.iter;
    assign ys     = r_cy >>> i_cmd.iter;
    assign atan_v = $signed({4'd0, atan_entry(i_cmd.iter)});

    always_comb begin
        h17  = $signed({r_heading[15], r_heading});
        hf   = h17;
        fold = 1'b0;
        if (h17 > 17'sd16384) begin
            hf   = h17 - 17'sd32768;
            fold = 1'b1;
        end else if (h17 < -17'sd16384) begin
            hf   = h17 + 17'sd32768;
            fold = 1'b1;
        end
        z_init = $signed({hf[16], hf, 16'd0});
        x_init = $signed({{2{r_x0[31]}}, r_x0});
        if (fold) begin
            x_init = -x_init;
        end
    end

    // pose update
    logic signed [33:0] xr, yr, xinc, yinc;
    logic [31:0]        nx, ny;
    logic [15:0]        nh;
    logic [63:0]        drain_rnd;
    logic [31:0]        drain;
    logic [23:0]        nbat;

    assign xr        = r_cx + 34'sd128;
    assign yr        = r_cy + 34'sd128;
    assign xinc      = xr >>> 8;
    assign yinc      = yr >>> 8;
    assign nx        = r_pose_x + xinc[31:0];
    assign ny        = r_pose_y + yinc[31:0];
    assign nh        = r_heading + r_bam;
    assign drain_rnd = r_acc + 64'h0000_0000_8000_0000;
    assign drain     = drain_rnd[63:32];
    assign nbat      = (drain >= {8'd0, r_battery}) ? 24'd0 : (r_battery - drain[23:0]);

    // control-relevant state; the initial battery setting only acts by reloading the level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd       <= RST_WHEEL_DIAMETER;
            r_isep     <= RST_INV_WHEEL_SEP;
            r_qd       <= RST_QUIESCENT_DRAIN;
            r_md       <= RST_MOTION_DRAIN;
            r_battery  <= RST_INITIAL_BATTERY;
            r_pose_x   <= '0;
            r_pose_y   <= '0;
            r_heading  <= '0;
            r_mop      <= MOP_NONE;
        end else begin
            r_mop <= i_cmd.mop;
            if (i_cmd.commit) begin
                r_pose_x  <= nx;
                r_pose_y  <= ny;
                r_heading <= nh;
                r_battery <= nbat;
            end
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_WHEEL_DIAMETER:  r_wd      <= i_cfg.data[15:0];
                    CFG_INV_WHEEL_SEP:   r_isep    <= i_cfg.data[23:0];
                    CFG_QUIESCENT_DRAIN: r_qd      <= i_cfg.data;
                    CFG_MOTION_DRAIN:    r_md      <= i_cfg.data;
                    CFG_INITIAL_BATTERY: r_battery <= i_cfg.data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_step <= i_in_data.step_time;
            r_rl   <= i_in_data.left_wheel_rate;
            r_rr   <= i_in_data.right_wheel_rate;
        end
        r_prod <= $signed(mul_a) * $signed(mul_b);
        if (acc_wr) begin
            r_acc <= wb_val;
        end
        case (r_mop)
            MOP_PL:     r_pl   <= wb_val[39:0];
            MOP_PR:     r_pr   <= wb_val[39:0];
            MOP_LIN:    r_lin  <= wb_val[49:18];
            MOP_ANGW:   r_angw <= wb_val[41:16];
            MOP_ANG:    r_ang  <= wb_val[48:17];
            MOP_D1_HI:  r_d1   <= wb_val[63:25];
            MOP_D2_HI:  r_d2   <= wb_val[63:25];
            MOP_DA_HI:  r_dat  <= wb_val[63:24];
            MOP_BAM_HI: r_bam  <= bam_rnd[47:32];
            MOP_X0:     r_x0   <= wb_val[63:32];
            MOP_SQ1, MOP_SQ2: r_sq <= wb_val[60:0];
            default: ;
        endcase
        if (i_cmd.cordic_init) begin
            r_cx <= x_init;
            r_cy <= '0;
            r_cz <= z_init;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_v;
            end
        end
        if (i_cmd.commit) begin
            r_out.pos_x            <= nx;
            r_out.pos_y            <= ny;
            r_out.heading          <= nh;
            r_out.linear_velocity  <= r_lin;
            r_out.angular_velocity <= r_ang;
            r_out.battery_volts    <= nbat;
            r_out.battery_empty    <= (nbat == 24'd0);
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== hw/rtl/diff_drive_odometry_core.sv =====
// diff_drive_odometry_core: top level of the differential-drive odometry core
// depends on ddo_pkg, ddo_in_if, ddo_out_if, ddo_ctrl and ddo_datapath

// One input transfer carries a time step and the two wheel angle rates; one result
// transfer follows with the pose after the step (x, y, binary-angle heading), the
// forward and turn rates and the battery level with its empty flag. After the input
// transfer the core runs 21 slots on the one shared 33x33 multiplier, one cordic load,
// N cordic iterations, where N is the cordic stage count (CORDIC_STAGES, capped at 24),
// and a commit. Input is taken again in the cycle after the commit, so a new step is
// taken only once the previous one is committed. The result sits in an output register,
// so a new step is taken while the previous result still waits. Configuration is written
// through a plain write port; the user must write it only while the core is idle, and the
// core does not enforce this. Writing the initial battery also reloads the battery level.
module diff_drive_odometry_core #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ddo_in_if.sink            i_in,
    ddo_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import ddo_pkg::*;

    // stage count beyond the arctan table acts as the full table
    localparam int unsigned N_ITER = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    t_cmd    cmd;
    t_cfg_wr cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // sequencer: multiplier slots, cordic iterations, result hand-off
    ddo_ctrl #(
        .N_ITER (N_ITER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // arithmetic, pose state and result register
    ddo_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .i_in_data  (i_in.data),
        .o_out_data (o_out.data)
    );

    // the sequencer stops taking steps right after a transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

    // a commit never overwrites a result that has not been taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before transfer");

    // a result appears only from a commit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

endmodule
